FILE: src/fba_pkg.sv
package fba_pkg;

	localparam int IDX_W         = 10;
	localparam int CFG_W         = 11;
	localparam int DEPTH_DEFAULT = 1024;
	localparam int COUNT_RESET   = 1024;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic             func;
		logic [IDX_W-1:0] free_index;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] block_index;
		logic [1:0]       status;
	} out_item_t;

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_EXEC
	} fsm_state_t;

endpackage

FILE: src/fba_ram.sv
module fba_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/fba_init.sv
module fba_init #(
	parameter int DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [$clog2(DEPTH+1)-1:0] count,
	output logic                       busy,
	output logic                       wr_en,
	output logic [$clog2(DEPTH)-1:0]   wr_addr,
	output logic [$clog2(DEPTH+1)-1:0] wr_data
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	logic             busy_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] idx_next;
	logic             last;

	assign idx_next = idx_q + CNT_W'(1);
	assign last     = (idx_next == count);

	// reset leaves the sweep running from entry zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_next;
		end
	end

	assign busy    = busy_q;
	assign wr_en   = busy_q && !start;
	assign wr_addr = idx_q[ADDR_W-1:0];
	// last entry closes the list with the end marker
	assign wr_data = last ? CNT_W'(DEPTH) : idx_next;

endmodule

FILE: src/fixed_block_free_list_allocator_unit.sv
// Free-list block allocator: one link memory entry per block, head pointer in a register.
// The result is written to the output register from S_EXEC, which holds while the output register is still full.
// A new item is taken only in S_IDLE, after the previous one has left S_EXEC.
// Reset (arst_n, async low): head clears to 0 and the list is rebuilt by a sweep over
// the block_count entries, with in_ready low; a block_count write repeats that sweep.
module fixed_block_free_list_allocator_unit #(
	parameter int DEPTH = fba_pkg::DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [fba_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  fba_pkg::in_item_t        in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output fba_pkg::out_item_t       out_data
);

	import fba_pkg::*;

	localparam int ADDR_W = $clog2(DEPTH);
	// pointers carry the end marker DEPTH, hence one value more than the address
	localparam int CNT_W  = $clog2(DEPTH + 1);
	// common width for range compares against the 10-bit index and 11-bit config
	localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int RESET_COUNT = (COUNT_RESET > DEPTH) ? DEPTH : COUNT_RESET;

	fsm_state_t state_q, state_d;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] head_q;
	in_item_t         item_q;
	out_item_t        out_q;
	logic             out_valid_q;

	logic [CMP_W-1:0] cfg_ext;
	logic [CNT_W-1:0] eff_count;

	logic              init_busy;
	logic              init_we;
	logic [ADDR_W-1:0] init_addr;
	logic [CNT_W-1:0]  init_data;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CNT_W-1:0]  ram_wdata;
	logic [CNT_W-1:0]  link_rdata;

	logic             exec_fire;
	logic [CMP_W-1:0] head_ext;
	logic [CMP_W-1:0] idx_ext;
	logic             pool_empty;
	logic             idx_bad;
	logic             do_pop;
	logic             do_push;
	out_item_t        result;

	// Block count clamp: zero acts as one, anything above DEPTH as DEPTH.
	always_comb begin
		cfg_ext = CMP_W'(cfg_wr_data);
		if (cfg_ext == '0) begin
			eff_count = CNT_W'(1);
		end else if (cfg_ext > CMP_W'(DEPTH)) begin
			eff_count = CNT_W'(DEPTH);
		end else begin
			eff_count = cfg_ext[CNT_W-1:0];
		end
	end

	// List build sequencer: chains entries 0..count-1 one per cycle.
	fba_init #(
		.DEPTH(DEPTH)
	) u_init (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_wr_en),
		.count  (count_q),
		.busy   (init_busy),
		.wr_en  (init_we),
		.wr_addr(init_addr),
		.wr_data(init_data)
	);

	// Link memory: read port always points at the head, so the next link is
	// already registered by the time the FSM is in S_EXEC. Head only moves at
	// the end of S_EXEC or on a count write; after S_EXEC the FSM passes
	// through S_IDLE, so the read never races a push to the same entry.
	fba_ram #(
		.WIDTH(CNT_W),
		.DEPTH(DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(head_q[ADDR_W-1:0]),
		.rdata(link_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (!init_busy) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
		if (cfg_wr_en) begin
			state_d = S_INIT;
		end
	end

	// FSM outputs
	always_comb begin
		in_ready  = 1'b0;
		exec_fire = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_EXEC: begin
				// output register free, or being drained this cycle
				exec_fire = !out_valid_q || out_ready;
			end
			default: begin
				in_ready  = 1'b0;
				exec_fire = 1'b0;
			end
		endcase
	end

	// Operation decode on the captured item
	always_comb begin
		head_ext   = CMP_W'(head_q);
		idx_ext    = CMP_W'(item_q.free_index);
		pool_empty = head_ext >= CMP_W'(count_q);
		idx_bad    = idx_ext >= CMP_W'(count_q);
		do_pop     = exec_fire && (item_q.func == FUNC_ALLOC) && !pool_empty;
		do_push    = exec_fire && (item_q.func == FUNC_FREE) && !idx_bad;

		if (item_q.func == FUNC_ALLOC) begin
			if (pool_empty) begin
				result.block_index = '0;
				result.status      = STATUS_EMPTY;
			end else begin
				result.block_index = head_ext[IDX_W-1:0];
				result.status      = STATUS_OK;
			end
		end else begin
			result.block_index = item_q.free_index;
			result.status      = idx_bad ? STATUS_RANGE : STATUS_OK;
		end
	end

	// Memory write port: the build sweep owns it while running, else a push
	// stores the old head as the link of the freed block.
	always_comb begin
		if (init_busy) begin
			ram_we    = init_we;
			ram_waddr = init_addr;
			ram_wdata = init_data;
		end else begin
			ram_we    = do_push;
			ram_waddr = idx_ext[ADDR_W-1:0];
			ram_wdata = head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			count_q     <= CNT_W'(RESET_COUNT);
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				count_q <= eff_count;
				head_q  <= '0;
			end else if (do_pop) begin
				head_q <= link_rdata;
			end else if (do_push) begin
				head_q <= idx_ext[CNT_W-1:0];
			end
			if (exec_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		if (exec_fire) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// no transfer is taken while the list is being rebuilt
	a_no_accept_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !in_ready)
		else $error("input transfer allowed during list build");

	// head only moves at the end of an operation or on a count write
	a_head_stable_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !cfg_wr_en) |=> $stable(head_q))
		else $error("head moved outside an operation");

	// a new result only appears out of the execute state
	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EXEC))
		else $error("result without an operation");

	// any successful grant or free names a block inside the pool
	a_ok_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == STATUS_OK)
		|-> (CMP_W'(out_q.block_index) < CMP_W'(count_q)))
		else $error("ok result outside the pool");
`endif

endmodule
